### src/sswm_pkg.sv
// ----------------------------------------------------------------------------
// Skid-steer wheel speed mapper package
// Shared payload types, opcodes, register indexes and state encodings.
// ----------------------------------------------------------------------------
package sswm_pkg;

  typedef enum logic [1:0] {
    OP_VEL  = 2'd0,
    OP_LIN  = 2'd1,
    OP_ANG  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_RAD = 2'd2,
    ST_RSV = 2'd3
  } status_e;

  localparam logic [2:0] REG_BYPASS  = 3'd0;
  localparam logic [2:0] REG_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_SEP     = 3'd2;
  localparam logic [2:0] REG_RADIUS  = 3'd3;
  localparam logic [2:0] REG_LTERMS  = 3'd4;
  localparam logic [2:0] REG_ATERMS  = 3'd5;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] angular_velocity;
    logic [15:0]        command_age_ms;
    logic [2:0]         coef_index;
    logic signed [31:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] left_wheel_speed;
    logic signed [31:0] right_wheel_speed;
    logic [1:0]         status;
    logic               timed_out;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_HMUL,
    S_HADD,
    S_KPREP,
    S_KMUL,
    S_KSUM,
    S_DIV,
    S_DFIN,
    S_OUT
  } state_e;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
  } div_ctl_t;

endpackage

### src/sswm_div.sv
// ----------------------------------------------------------------------------
// Skid-steer wheel speed mapper divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sswm_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [32:0] divisor_i,
  output sswm_pkg::div_ctl_t ctl_o,
  output logic [63:0] quot_o
);

  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [33:0] trial;

  assign trial = {rem_q, quot_q[63]};

  // Shift one dividend bit in and try a subtract
  always_comb begin
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d  = 7'd64;
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (cnt_q != 7'd0) begin
      cnt_d = cnt_q - 7'd1;
      if (trial >= {1'b0, divisor_i}) begin
        rem_d  = 33'(trial - {1'b0, divisor_i});
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = trial[32:0];
        quot_d = {quot_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign ctl_o.busy  = (cnt_q != 7'd0);
  assign quot_o      = quot_q;

endmodule

### src/skid_steer_wheel_speed_mapper_core.sv
// ----------------------------------------------------------------------------
// Skid-steer wheel speed mapper
// Differential drive inverse kinematics with polynomial velocity correction.
// ----------------------------------------------------------------------------
// Usage: items enter on the in channel (valid/stall). A velocity command
// (op 0) yields one transaction on the out channel with left and right
// wheel speeds; coefficient writes (op 1, 2) update the tables when accepted
// and give no result. Op 3 is dropped.
// A command runs through one shared 32x33 multiplier for the Horner steps
// (S_HMUL, S_HADD per step, up to MAX_TERMS-1 steps per polynomial) and the
// separation product, then a bit-serial divider (64 steps) for each wheel.
// A zero radius skips the divider; bypass skips the Horner steps.
// The block takes no new item until the result is taken by the receiver:
// stall on the out channel holds the result register and the in side.
// Reset clears the coefficient tables and loads register defaults
// (timeout 500 ms, separation and radius 1.0, 5 and 7 terms).
// Configuration through the APB port: registers at byte address 4*index.
// ----------------------------------------------------------------------------
module skid_steer_wheel_speed_mapper_core #(
  parameter int MAX_TERMS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sswm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sswm_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int TW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = TW + 1;

  // Configuration registers
  logic        byp_q;
  logic [15:0] tmo_q;
  logic [31:0] sep_q, rad_q;
  logic [3:0]  lterms_q, aterms_q;
  logic        wr_en;
  logic [2:0]  widx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign widx   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q    <= 1'b0;
      tmo_q    <= 16'd500;
      sep_q    <= 32'd65536;
      rad_q    <= 32'd65536;
      lterms_q <= 4'd5;
      aterms_q <= 4'd7;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      unique case (widx)
        sswm_pkg::REG_BYPASS:  byp_q    <= pwdata[0];
        sswm_pkg::REG_TIMEOUT: tmo_q    <= pwdata[15:0];
        sswm_pkg::REG_SEP:     sep_q    <= pwdata;
        sswm_pkg::REG_RADIUS:  rad_q    <= pwdata;
        sswm_pkg::REG_LTERMS:  lterms_q <= pwdata[3:0];
        sswm_pkg::REG_ATERMS:  aterms_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (widx)
      sswm_pkg::REG_BYPASS:  prdata = {31'd0, byp_q};
      sswm_pkg::REG_TIMEOUT: prdata = {16'd0, tmo_q};
      sswm_pkg::REG_SEP:     prdata = sep_q;
      sswm_pkg::REG_RADIUS:  prdata = rad_q;
      sswm_pkg::REG_LTERMS:  prdata = {28'd0, lterms_q};
      sswm_pkg::REG_ATERMS:  prdata = {28'd0, aterms_q};
      default:               prdata = '0;
    endcase
  end

  // Coefficient tables (small, cleared at reset)
  logic signed [31:0] ltab_q [MAX_TERMS];
  logic signed [31:0] atab_q [MAX_TERMS];
  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TERMS; i++) begin
        ltab_q[i] <= '0;
        atab_q[i] <= '0;
      end
    end else if (in_acc && 32'(in_data_i.coef_index) < 32'(MAX_TERMS)) begin
      if (in_data_i.op == sswm_pkg::OP_LIN) ltab_q[TW'(in_data_i.coef_index)] <=
        in_data_i.coef_value;
      if (in_data_i.op == sswm_pkg::OP_ANG) atab_q[TW'(in_data_i.coef_index)] <=
        in_data_i.coef_value;
    end
  end

  // Sequencer state and datapath registers
  sswm_pkg::state_e st_q, st_d;
  logic               pass_q;   // 0 linear, 1 angular
  logic [CW-1:0]      k_q;      // remaining Horner steps
  logic signed [31:0] x_q, acc_q, v_q, w_q;
  logic signed [63:0] prod_q;
  logic               sat_q, stale_q, side_q;
  logic               an_q, pn_q;
  logic [63:0]        am_q, pm_q;
  logic signed [31:0] left_q;
  sswm_pkg::out_item_t out_q;
  logic               out_v_q;

  logic [CW-1:0] nterms;
  logic [3:0]    tsel;
  assign tsel   = pass_q ? aterms_q : lterms_q;
  assign nterms = (32'(tsel) > MAX_TERMS) ? CW'(MAX_TERMS) : CW'(tsel);

  // Shared multiplier operands
  logic signed [31:0] ma;
  logic signed [32:0] mb;
  logic signed [64:0] mprod;
  always_comb begin
    if (st_q == sswm_pkg::S_KMUL) begin
      ma = w_q;
      mb = $signed({1'b0, sep_q});
    end else begin
      ma = acc_q;
      mb = 33'(x_q);
    end
  end
  assign mprod = ma * mb;

  // Horner add with floor shift and saturation
  logic signed [47:0] hsum;
  logic signed [31:0] cnext;
  logic               hsat;
  assign cnext = pass_q ? atab_q[TW'(k_q - CW'(1))] : ltab_q[TW'(k_q - CW'(1))];
  assign hsum  = 48'(prod_q >>> 16) + 48'(cnext);
  assign hsat  = (hsum > 48'sd2147483647) || (hsum < -48'sd2147483648);

  // Sign-magnitude sum for one wheel
  logic        eff_pn, rn;
  logic [63:0] rm;
  assign eff_pn = side_q ? pn_q : ((pm_q == 64'd0) ? 1'b0 : ~pn_q);
  always_comb begin
    if (an_q == eff_pn) begin
      rn = an_q;
      rm = am_q + pm_q;
    end else if (am_q >= pm_q) begin
      rn = an_q;
      rm = am_q - pm_q;
    end else begin
      rn = eff_pn;
      rm = pm_q - am_q;
    end
    if (rm == 64'd0) rn = 1'b0;
  end

  sswm_pkg::div_ctl_t dctl;
  logic [63:0]        quot;
  logic               dstart;
  assign dstart = (st_q == sswm_pkg::S_KSUM);

  sswm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dstart),
    .dividend_i (rm),
    .divisor_i  ({rad_q, 1'b0}),
    .ctl_o      (dctl),
    .quot_o     (quot)
  );

  // Wheel result saturation
  logic signed [31:0] wres;
  logic               wsat;
  always_comb begin
    wsat = 1'b0;
    if (!rn) begin
      if (quot > 64'h7FFF_FFFF) begin
        wsat = 1'b1;
        wres = 32'sh7FFF_FFFF;
      end else begin
        wres = quot[31:0];
      end
    end else if (quot > 64'h8000_0000) begin
      wsat = 1'b1;
      wres = 32'sh8000_0000;
    end else begin
      wres = 32'(-quot);
    end
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      sswm_pkg::S_IDLE:
        if (in_acc && in_data_i.op == sswm_pkg::OP_VEL) begin
          st_d = byp_q ? sswm_pkg::S_KPREP : sswm_pkg::S_LOAD;
        end
      sswm_pkg::S_LOAD:
        st_d = (nterms > CW'(1)) ? sswm_pkg::S_HMUL :
               (pass_q ? sswm_pkg::S_KPREP : sswm_pkg::S_LOAD);
      sswm_pkg::S_HMUL: st_d = sswm_pkg::S_HADD;
      sswm_pkg::S_HADD:
        if (k_q > CW'(1)) st_d = sswm_pkg::S_HMUL;
        else st_d = pass_q ? sswm_pkg::S_KPREP : sswm_pkg::S_LOAD;
      sswm_pkg::S_KPREP:
        st_d = (rad_q == 32'd0) ? sswm_pkg::S_OUT : sswm_pkg::S_KMUL;
      sswm_pkg::S_KMUL: st_d = sswm_pkg::S_KSUM;
      sswm_pkg::S_KSUM: st_d = sswm_pkg::S_DIV;
      sswm_pkg::S_DIV:  if (!dctl.busy) st_d = sswm_pkg::S_DFIN;
      sswm_pkg::S_DFIN: st_d = side_q ? sswm_pkg::S_OUT : sswm_pkg::S_KSUM;
      sswm_pkg::S_OUT:  if (!out_stall_i) st_d = sswm_pkg::S_IDLE;
      default:          st_d = sswm_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall_o  = (st_q != sswm_pkg::S_IDLE);
    out_valid_o = out_v_q;
    out_data_o  = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= sswm_pkg::S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      out_v_q <= (st_q == sswm_pkg::S_OUT) ? ~out_stall_i ? 1'b0 : out_v_q :
                 (st_d == sswm_pkg::S_OUT && st_q != sswm_pkg::S_OUT);
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      sswm_pkg::S_IDLE: begin
        pass_q  <= 1'b0;
        sat_q   <= 1'b0;
        side_q  <= 1'b0;
        stale_q <= in_data_i.command_age_ms > tmo_q;
        if (in_data_i.command_age_ms > tmo_q) begin
          v_q <= '0;
          w_q <= '0;
        end else begin
          v_q <= in_data_i.linear_velocity;
          w_q <= in_data_i.angular_velocity;
        end
      end
      sswm_pkg::S_LOAD: begin
        x_q <= pass_q ? w_q : v_q;
        k_q <= nterms - CW'(1);
        if (nterms == CW'(0)) acc_q <= '0;
        else acc_q <= pass_q ? atab_q[TW'(nterms - CW'(1))] :
                               ltab_q[TW'(nterms - CW'(1))];
        if (nterms <= CW'(1)) begin
          // finish this pass straight away
          if (nterms == CW'(0)) begin
            if (pass_q) w_q <= '0; else v_q <= '0;
          end else if (pass_q) w_q <= atab_q[0];
          else v_q <= ltab_q[0];
          pass_q <= 1'b1;
        end
      end
      sswm_pkg::S_HMUL: prod_q <= 64'(mprod);
      sswm_pkg::S_HADD: begin
        k_q   <= k_q - CW'(1);
        acc_q <= hsat ? (hsum < 0 ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : hsum[31:0];
        if (hsat) sat_q <= 1'b1;
        if (k_q == CW'(1)) begin
          if (pass_q) w_q <= hsat ? (hsum < 0 ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                  : hsum[31:0];
          else v_q <= hsat ? (hsum < 0 ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                           : hsum[31:0];
          pass_q <= 1'b1;
        end
      end
      sswm_pkg::S_KPREP: begin
        an_q <= v_q[31];
        am_q <= {15'd0, (v_q[31] ? 32'(-v_q) : v_q), 17'd0};
      end
      sswm_pkg::S_KMUL: begin
        pn_q <= mprod[64];
        pm_q <= mprod[64] ? 64'(-mprod) : 64'(mprod);
      end
      sswm_pkg::S_DFIN: begin
        if (wsat) sat_q <= 1'b1;
        if (!side_q) left_q <= wres;
        side_q <= 1'b1;
      end
      default: ;
    endcase
    if (st_q != sswm_pkg::S_OUT && st_d == sswm_pkg::S_OUT) begin
      out_q.timed_out <= stale_q;
      if (rad_q == 32'd0) begin
        out_q.left_wheel_speed  <= '0;
        out_q.right_wheel_speed <= '0;
        out_q.status            <= sswm_pkg::ST_RAD;
      end else begin
        out_q.left_wheel_speed  <= left_q;
        out_q.right_wheel_speed <= wres;
        out_q.status            <= (sat_q | wsat) ? sswm_pkg::ST_SAT : sswm_pkg::ST_OK;
      end
    end
  end

endmodule

### src/sswm_checker.sv
// ----------------------------------------------------------------------------
// Skid-steer wheel speed mapper checker
// Port-level properties of the mapper, bound to the top level.
// ----------------------------------------------------------------------------
module sswm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sswm_pkg::out_item_t out_data_o
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");

  // Never take input while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  // Radius flag zeroes both speeds
  a_rad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == sswm_pkg::ST_RAD |->
      out_data_o.left_wheel_speed == 0 && out_data_o.right_wheel_speed == 0)
    else $error("radius flag with nonzero speed");

  // Status code three is never produced
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != sswm_pkg::ST_RSV)
    else $error("reserved status");

endmodule

bind skid_steer_wheel_speed_mapper_core sswm_checker u_sswm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### dv/skid_steer_wheel_speed_mapper_core_tb.sv
// ----------------------------------------------------------------------------
// Skid-steer wheel speed mapper testbench
// Drives coefficient writes and velocity commands through the valid/stall
// channel under several idling phases, predicts each wheel speed result and
// compares every field. Registers are reprogrammed over APB while idle.
// ----------------------------------------------------------------------------
module skid_steer_wheel_speed_mapper_core_tb;

  localparam int NTERMS    = 8;
  localparam int IDLE_WAIT = 400;
  localparam int WDOG_MAX  = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  sswm_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  sswm_pkg::out_item_t out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [4:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  skid_steer_wheel_speed_mapper_core #(.MAX_TERMS(NTERMS)) DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: shadow registers and coefficient tables
  logic               mdl_bypass;
  logic [15:0]        mdl_timeout;
  logic [31:0]        mdl_sep;
  logic [31:0]        mdl_radius;
  logic [3:0]         mdl_lterms;
  logic [3:0]         mdl_aterms;
  logic signed [31:0] mdl_lin_coef [NTERMS];
  logic signed [31:0] mdl_ang_coef [NTERMS];

  sswm_pkg::out_item_t speed_q [$];
  int        n_errors = 0;
  int        n_results = 0;
  int        n_cmds = 0;
  int        n_coefs = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        quiet_cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Horner step with floor division by 2^16 and 32-bit saturation
  function automatic logic signed [31:0] eval_poly(input logic signed [31:0] tab [NTERMS],
      input logic [3:0] terms, input logic signed [31:0] x, inout bit sat);
    int n;
    longint acc, p;
    n = (terms > NTERMS) ? NTERMS : terms;
    if (n == 0) return 0;
    acc = tab[n-1];
    for (int i = n - 1; i > 0; i--) begin
      p = acc * longint'(x);
      acc = (p >>> 16) + longint'(tab[i-1]);
      if (acc > 64'sd2147483647) begin
        acc = 64'sd2147483647; sat = 1;
      end else if (acc < -64'sd2147483648) begin
        acc = -64'sd2147483648; sat = 1;
      end
    end
    return acc[31:0];
  endfunction

  function automatic logic signed [31:0] wheel_quot(input logic signed [65:0] num,
      input logic [33:0] den, inout bit sat);
    logic [65:0] mag, q;
    bit neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = mag / den;
    if (!neg && q > 66'h7FFFFFFF) begin sat = 1; return 32'h7FFFFFFF; end
    if (neg && q > 66'h80000000) begin sat = 1; return 32'h80000000; end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  // Apply one accepted item to the predictor
  function automatic void predict_speeds(input sswm_pkg::in_item_t it);
    logic signed [31:0] v, w;
    logic signed [65:0] a, p;
    sswm_pkg::out_item_t r;
    bit sat, stale;
    case (sswm_pkg::op_e'(it.op))
      sswm_pkg::OP_LIN: mdl_lin_coef[it.coef_index] = it.coef_value;
      sswm_pkg::OP_ANG: mdl_ang_coef[it.coef_index] = it.coef_value;
      sswm_pkg::OP_VEL: begin
        sat = 0;
        v = it.linear_velocity;
        w = it.angular_velocity;
        stale = it.command_age_ms > mdl_timeout;
        if (stale) begin v = 0; w = 0; end
        if (!mdl_bypass) begin
          v = eval_poly(mdl_lin_coef, mdl_lterms, v, sat);
          w = eval_poly(mdl_ang_coef, mdl_aterms, w, sat);
        end
        r = '0;
        r.timed_out = stale;
        if (mdl_radius == 0) begin
          r.status = sswm_pkg::ST_RAD;
        end else begin
          a = 66'(v) * 66'sd131072;
          p = 66'(w) * $signed({34'd0, mdl_sep});
          r.left_wheel_speed  = wheel_quot(a - p, {1'b0, mdl_radius, 1'b0}, sat);
          r.right_wheel_speed = wheel_quot(a + p, {1'b0, mdl_radius, 1'b0}, sat);
          r.status = sat ? sswm_pkg::ST_SAT : sswm_pkg::ST_OK;
        end
        speed_q.insert(speed_q.size(), r);
      end
      default: ;
    endcase
  endfunction

  // Accept transactions on both channels at the rising edge
  always @(posedge clk_i) begin
    sswm_pkg::out_item_t want;
    bit seen;
    seen = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_speeds(in_data_i);
        seen = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        seen = 1'b1;
        n_results++;
        if (speed_q.size() == 0) begin
          report_mismatch("unexpected result", out_data_o.left_wheel_speed, 0);
        end else begin
          want = speed_q.pop_front();
          if (out_data_o.left_wheel_speed !== want.left_wheel_speed)
            report_mismatch("left", out_data_o.left_wheel_speed, want.left_wheel_speed);
          if (out_data_o.right_wheel_speed !== want.right_wheel_speed)
            report_mismatch("right", out_data_o.right_wheel_speed,
                            want.right_wheel_speed);
          if (out_data_o.status !== want.status)
            report_mismatch("status", out_data_o.status, want.status);
          if (out_data_o.timed_out !== want.timed_out)
            report_mismatch("timed_out", out_data_o.timed_out, want.timed_out);
        end
      end
      quiet_cycles <= seen ? 0 : quiet_cycles + 1;
    end
  end

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (quiet_cycles >= WDOG_MAX) begin
      $display("watchdog expired");
      $display("skid_steer_wheel_speed_mapper_core_tb failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      sswm_pkg::REG_BYPASS:  mdl_bypass  = val[0];
      sswm_pkg::REG_TIMEOUT: mdl_timeout = val[15:0];
      sswm_pkg::REG_SEP:     mdl_sep     = val;
      sswm_pkg::REG_RADIUS:  mdl_radius  = val;
      sswm_pkg::REG_LTERMS:  mdl_lterms  = val[3:0];
      sswm_pkg::REG_ATERMS:  mdl_aterms  = val[3:0];
      default: ;
    endcase
  endtask

  // Send one item, with optional idle cycles before it
  task automatic send_item(input sswm_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    if (sswm_pkg::op_e'(it.op) == sswm_pkg::OP_VEL) n_cmds++; else n_coefs++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (speed_q.size() != 0) @(negedge clk_i);
    repeat (IDLE_WAIT) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(131072) - 65536;
      3: return $urandom_range(1024) - 512;
      default: return $urandom;
    endcase
  endfunction

  function automatic sswm_pkg::in_item_t vel_item(input logic [31:0] v,
      input logic [31:0] w, input logic [15:0] age);
    sswm_pkg::in_item_t it;
    it = '0;
    it.op = sswm_pkg::OP_VEL; it.linear_velocity = v; it.angular_velocity = w;
    it.command_age_ms = age;
    it.coef_index = 3'($urandom); it.coef_value = $urandom;
    return it;
  endfunction

  function automatic sswm_pkg::in_item_t coef_item(input sswm_pkg::op_e op,
      input logic [2:0] idx, input logic [31:0] val);
    sswm_pkg::in_item_t it;
    it = '0;
    it.linear_velocity = $urandom; it.angular_velocity = $urandom;
    it.command_age_ms = 16'($urandom);
    it.op = op; it.coef_index = idx; it.coef_value = val;
    return it;
  endfunction

  // Extremes, timeout, bypass, radius zero, term counts, ignored opcode
  task automatic test_directed();
    sswm_pkg::in_item_t it;
    send_item(vel_item(32'h00010000, 32'h00010000, 16'd0));
    send_item(coef_item(sswm_pkg::OP_LIN, 3'd0, 32'h00008000));
    send_item(coef_item(sswm_pkg::OP_LIN, 3'd1, 32'h00010000));
    send_item(coef_item(sswm_pkg::OP_ANG, 3'd1, 32'h00010000));
    send_item(coef_item(sswm_pkg::OP_ANG, 3'd7, 32'h7FFFFFFF));
    send_item(vel_item(32'h7FFFFFFF, 32'h80000000, 16'd500));
    send_item(vel_item(32'h00020000, 32'hFFFF0000, 16'd501));
    send_item(vel_item(32'h80000000, 32'h7FFFFFFF, 16'hFFFF));
    it = vel_item(32'h00010000, 32'h00010000, 16'd0);
    it.op = sswm_pkg::OP_NONE;
    send_item(it);
    drain();
    write_reg(sswm_pkg::REG_BYPASS, 32'd1);
    write_reg(sswm_pkg::REG_TIMEOUT, 32'hFFFF);
    write_reg(sswm_pkg::REG_SEP, 32'hFFFFFFFF);
    write_reg(sswm_pkg::REG_RADIUS, 32'd1);
    send_item(vel_item(32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF));
    send_item(vel_item(32'h80000000, 32'h80000000, 16'd0));
    drain();
    write_reg(sswm_pkg::REG_RADIUS, 32'd0);
    write_reg(sswm_pkg::REG_TIMEOUT, 32'd0);
    send_item(vel_item(32'h00030000, 32'h00010000, 16'd1));
    drain();
    write_reg(sswm_pkg::REG_BYPASS, 32'd0);
    write_reg(sswm_pkg::REG_RADIUS, 32'hFFFFFFFF);
    write_reg(sswm_pkg::REG_LTERMS, 32'd0);
    write_reg(sswm_pkg::REG_ATERMS, 32'd15);
    send_item(vel_item(32'h00050000, 32'hFFFB0000, 16'd0));
    drain();
    write_reg(sswm_pkg::REG_LTERMS, 32'd1);
    write_reg(sswm_pkg::REG_ATERMS, 32'd8);
    send_item(vel_item(32'h00020000, 32'h00020000, 16'd0));
    drain();
  endtask

  // Random coefficient loads, ignored items and commands; configuration redrawn every 60 items
  task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
    logic [31:0] cfg [6];
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 60 == 0) begin
        drain();
        cfg[0] = 32'($urandom_range(3) == 0);
        cfg[1] = $urandom_range(1) ? $urandom_range(1000) : $urandom;
        cfg[2] = $urandom_range(1) ? $urandom_range(32'h40000) : $urandom;
        cfg[3] = $urandom_range(9) == 0 ? 0 :
                 ($urandom_range(1) ? $urandom_range(32'h40000) : $urandom);
        cfg[4] = $urandom_range(15);
        cfg[5] = $urandom_range(15);
        for (int r = 0; r < 6; r++) write_reg(r[2:0], cfg[r]);
      end
      case ($urandom_range(9))
        0, 1: send_item(coef_item($urandom_range(1) ? sswm_pkg::OP_LIN : sswm_pkg::OP_ANG,
                                  3'($urandom), rand_word()));
        2: send_item(coef_item(sswm_pkg::OP_NONE, 3'($urandom), $urandom));
        default: send_item(vel_item(rand_word(), rand_word(), 16'($urandom_range(1200))));
      endcase
      // hold off until every expected result is back
      if (i == n_items / 2) drain();
    end
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    mdl_bypass = 0; mdl_timeout = 16'd500; mdl_sep = 32'd65536; mdl_radius = 32'd65536;
    mdl_lterms = 4'd5; mdl_aterms = 4'd7;
    for (int i = 0; i < NTERMS; i++) begin
      mdl_lin_coef[i] = 0; mdl_ang_coef[i] = 0;
    end
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);
    test_directed();
    test_random(340, 0, 0);
    test_random(330, 65, 0);
    test_random(330, 0, 65);
    test_random(330, 23, 23);
    drain();
    $display("covered %0d velocity commands, %0d table writes and ignored items,",
             n_cmds, n_coefs);
    $display("%0d results checked across four idling phases", n_results);
    if (n_errors == 0 && speed_q.size() == 0) begin
      $display("skid_steer_wheel_speed_mapper_core_tb passed");
    end else begin
      $display("skid_steer_wheel_speed_mapper_core_tb failed");
    end
    $finish;
  end

endmodule
